[src/tbsc_pkg.sv]
`timescale 1ns / 1ps

package tbsc_pkg;

   localparam int NUM_BUTTONS = 8;
   localparam int NUM_BANKS = 3;
   localparam int NUM_GROUPS = 3;
   localparam int BANK_BITS = 2;
   localparam int SLOT_BITS = 4;

   localparam logic [BANK_BITS-1:0] BANK_FIRST = 2'd0;
   localparam logic [BANK_BITS-1:0] BANK_MIDDLE = 2'd1;
   localparam logic [BANK_BITS-1:0] BANK_LAST = 2'd2;
   localparam logic [BANK_BITS-1:0] BANK_UNUSED = 2'd3;

   localparam logic [SLOT_BITS-1:0] NO_BUTTON = 4'hF;
   localparam logic [7:0] CAL_ROUNDS_RESET = 8'd100;

   localparam int GRP_ONE = 0;
   localparam int GRP_FIVE = 1;
   localparam int GRP_SIX = 2;

   typedef struct packed {
      logic                 fire;
      logic [BANK_BITS-1:0] bank;
      logic [NUM_GROUPS-1:0] done;
      logic                 track_max;
      logic                 cal_next;
   } tbsc_ctl_type;

   // Button slot for a bank and group; bank 2 has no button on group six.
   function automatic logic [SLOT_BITS-1:0] slot_of(input logic [BANK_BITS-1:0] bank,
                                                    input logic [1:0] grp);
      logic [SLOT_BITS-1:0] slot;
      slot = NO_BUTTON;
      unique case ({bank, grp})
         {BANK_FIRST, 2'(GRP_ONE)}:   slot = 4'd0;
         {BANK_FIRST, 2'(GRP_FIVE)}:  slot = 4'd7;
         {BANK_FIRST, 2'(GRP_SIX)}:   slot = 4'd5;
         {BANK_MIDDLE, 2'(GRP_ONE)}:  slot = 4'd1;
         {BANK_MIDDLE, 2'(GRP_FIVE)}: slot = 4'd6;
         {BANK_MIDDLE, 2'(GRP_SIX)}:  slot = 4'd3;
         {BANK_LAST, 2'(GRP_ONE)}:    slot = 4'd4;
         {BANK_LAST, 2'(GRP_FIVE)}:   slot = 4'd2;
         default:                     slot = NO_BUTTON;
      endcase
      return slot;
   endfunction

endpackage

[src/tbsc_buttons.sv]
`timescale 1ns / 1ps

module tbsc_buttons #(
   parameter int COUNT_BITS = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tbsc_pkg::tbsc_ctl_type        ctl,
   input  logic [COUNT_BITS-1:0]         g1_count,
   input  logic [COUNT_BITS-1:0]         g5_count,
   input  logic [COUNT_BITS-1:0]         g6_count,
   output logic [tbsc_pkg::NUM_BUTTONS-1:0] pressed_next
);

   logic [COUNT_BITS-1:0] counts_ff [tbsc_pkg::NUM_BUTTONS];
   logic [COUNT_BITS-1:0] counts_in [tbsc_pkg::NUM_BUTTONS];
   logic [COUNT_BITS-1:0] maxima_ff [tbsc_pkg::NUM_BUTTONS];
   logic [COUNT_BITS-1:0] maxima_in [tbsc_pkg::NUM_BUTTONS];
   logic [COUNT_BITS-1:0] grp_count [tbsc_pkg::NUM_GROUPS];

   assign grp_count[tbsc_pkg::GRP_ONE] = g1_count;
   assign grp_count[tbsc_pkg::GRP_FIVE] = g5_count;
   assign grp_count[tbsc_pkg::GRP_SIX] = g6_count;

   always_comb begin
      for (int i = 0; i < tbsc_pkg::NUM_BUTTONS; i++) begin
         counts_in[i] = counts_ff[i];
         for (int g = 0; g < tbsc_pkg::NUM_GROUPS; g++) begin
            if (ctl.done[g] &&
                tbsc_pkg::slot_of(ctl.bank, 2'(g)) == tbsc_pkg::SLOT_BITS'(i)) begin
               counts_in[i] = grp_count[g];
            end
         end
         if (ctl.track_max && counts_in[i] > maxima_ff[i]) begin
            maxima_in[i] = counts_in[i];
         end else begin
            maxima_in[i] = maxima_ff[i];
         end
         pressed_next[i] = !ctl.cal_next && (counts_in[i] < (maxima_in[i] >> 1));
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < tbsc_pkg::NUM_BUTTONS; i++) begin
         if (reset) begin
            counts_ff[i] <= '0;
            maxima_ff[i] <= '0;
         end else if (ctl.fire) begin
            counts_ff[i] <= counts_in[i];
            maxima_ff[i] <= maxima_in[i];
         end
      end
   end

endmodule

[src/touch_button_scan_calibrate_unit.sv]
`timescale 1ns / 1ps
// Path: an accepted item is held in the input register, then in the result register.
// Throughput: one item per cycle if rsp_stall is low; set by input and result registers.
// Reset: synchronous, active high; clears counts, maxima, bank, round count, both
// pipeline valids, sets calibration active and loads cal_rounds with 100.

module touch_button_scan_calibrate_unit #(
   parameter int COUNT_BITS = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [7:0]            csr_wr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_g1_done,
   input  logic [COUNT_BITS-1:0] req_g1_count,
   input  logic                  req_g5_done,
   input  logic [COUNT_BITS-1:0] req_g5_count,
   input  logic                  req_g6_done,
   input  logic [COUNT_BITS-1:0] req_g6_count,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_pressed_mask,
   output logic                  rsp_calibrating,
   output logic [7:0]            rsp_round_count,
   output logic [1:0]            rsp_next_bank
);

   logic [7:0]                 cal_rounds_val_ff;
   logic                       s1_valid_ff;
   logic [tbsc_pkg::NUM_GROUPS-1:0] s1_done_ff;
   logic [COUNT_BITS-1:0]      s1_g1_count_ff;
   logic [COUNT_BITS-1:0]      s1_g5_count_ff;
   logic [COUNT_BITS-1:0]      s1_g6_count_ff;
   logic [tbsc_pkg::BANK_BITS-1:0] bank_ff;
   logic [tbsc_pkg::BANK_BITS-1:0] bank_in;
   logic [7:0]                 rounds_ff;
   logic [7:0]                 rounds_in;
   logic                       cal_active_ff;
   logic                       cal_active_in;
   logic                       rsp_valid_ff;
   logic [7:0]                 rsp_pressed_mask_ff;
   logic                       rsp_calibrating_ff;
   logic [7:0]                 rsp_round_count_ff;
   logic [1:0]                 rsp_next_bank_ff;
   logic                       out_free;
   logic                       s1_fire;
   logic                       req_fire;
   logic [tbsc_pkg::NUM_BUTTONS-1:0] pressed_next;
   tbsc_pkg::tbsc_ctl_type     ctl;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_fire = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_fire = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_rounds_val_ff <= tbsc_pkg::CAL_ROUNDS_RESET;
      end else if (csr_wr_en) begin
         cal_rounds_val_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_done_ff     <= {req_g6_done, req_g5_done, req_g1_done};
         s1_g1_count_ff <= req_g1_count;
         s1_g5_count_ff <= req_g5_count;
         s1_g6_count_ff <= req_g6_count;
      end
   end

   always_comb begin
      bank_in = bank_ff;
      rounds_in = rounds_ff;
      cal_active_in = cal_active_ff;
      if (bank_ff == tbsc_pkg::BANK_LAST) begin
         if (cal_active_ff && rounds_ff == cal_rounds_val_ff) begin
            cal_active_in = 1'b0;
         end
         rounds_in = rounds_ff + 8'd1;
         bank_in = tbsc_pkg::BANK_FIRST;
      end else if (bank_ff != tbsc_pkg::BANK_UNUSED) begin
         bank_in = bank_ff + 2'd1;
      end
      ctl.fire = s1_fire;
      ctl.bank = bank_ff;
      ctl.done = s1_done_ff;
      ctl.track_max = cal_active_ff && (bank_ff == tbsc_pkg::BANK_LAST);
      ctl.cal_next = cal_active_in;
   end

   tbsc_buttons #(
      .COUNT_BITS(COUNT_BITS)
   ) u_buttons (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .g1_count     (s1_g1_count_ff),
      .g5_count     (s1_g5_count_ff),
      .g6_count     (s1_g6_count_ff),
      .pressed_next (pressed_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= tbsc_pkg::BANK_FIRST;
         rounds_ff <= 8'd0;
         cal_active_ff <= 1'b1;
      end else if (s1_fire) begin
         bank_ff <= bank_in;
         rounds_ff <= rounds_in;
         cal_active_ff <= cal_active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_pressed_mask_ff <= pressed_next;
         rsp_calibrating_ff  <= cal_active_in;
         rsp_round_count_ff  <= rounds_in;
         rsp_next_bank_ff    <= bank_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pressed_mask = rsp_pressed_mask_ff;
   assign rsp_calibrating = rsp_calibrating_ff;
   assign rsp_round_count = rsp_round_count_ff;
   assign rsp_next_bank = rsp_next_bank_ff;

   a_mask_zero_calibrating: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_calibrating_ff |-> rsp_pressed_mask_ff == 8'd0)
      else $error("pressed mask set while calibrating");

   a_bank_in_range: assert property (@(posedge clock) disable iff (reset)
      bank_ff != tbsc_pkg::BANK_UNUSED)
      else $error("bank index holds unused code");

   a_cal_stays_off: assert property (@(posedge clock) disable iff (reset)
      !cal_active_ff |=> !cal_active_ff)
      else $error("calibration restarted without reset");

   a_round_end: assert property (@(posedge clock) disable iff (reset)
      s1_fire && bank_ff == tbsc_pkg::BANK_LAST |=>
         bank_ff == tbsc_pkg::BANK_FIRST && rounds_ff == $past(rounds_ff) + 8'd1)
      else $error("round end did not wrap bank or advance round count");

endmodule
